@@ hw/rtl/sphere_vertex_generator_macros.svh @@
// assertion helpers for the sphere vertex generator
`ifndef SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define SPHERE_VERTEX_GENERATOR_MACROS_SVH

// implication checked every clock outside reset
`define SVG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define SVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/svg_pkg.sv @@
package svg_pkg;

   localparam int PhaseW = 24;
   localparam int Q30W   = 32;
   localparam logic [31:0] OneQ30   = 32'd1073741824;
   localparam logic [31:0] TenthQ30 = 32'd107374182;
   localparam logic [31:0] TenthQ31 = 32'd214748365;

   typedef logic [31:0] coef_type [5];
   localparam coef_type PolyQ30 = '{
      32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172272
   };

   // data carried down the sine chain for one angle
   typedef struct packed {
      logic [1:0]  quad;
      logic [30:0] x;
      logic [30:0] x2;
      logic [31:0] acc;
   } sin_type;

   // sideband carried alongside the trig pipeline
   typedef struct packed {
      logic [9:0]  radius;
      logic [11:0] vertex_number;
      logic [12:0] ring_order_slot;
      logic        face_present;
      logic [11:0] corner_right;
      logic [11:0] corner_upper_right;
      logic [11:0] corner_above;
   } side_type;

   // round to nearest, halves away from zero, of a signed value by s bits
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int s);
      logic [63:0] mag;
      logic [63:0] half;
      begin
         half = 64'd1 << (s - 1);
         mag  = v[63] ? 64'(-v) : 64'(v);
         mag  = (mag + half) >> s;
         rnd_shift = v[63] ? -$signed(mag) : $signed(mag);
      end
   endfunction

   function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
      sat64 = (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

endpackage

@@ hw/rtl/sphere_vertex_generator.sv @@
// sphere_vertex_generator: lat/lon grid point to position, color and quad indices
// an accepted req word moves through stage registers 0..9 to the rsp word, held by any stall
// throughput one word per cycle; the whole pipe advances whenever the output is free
// reset clears the stage valids and sets the radius register to 50
// the datapath is four sine chains of horner cells, then product, round and radius scale stages
module sphere_vertex_generator #(
   parameter int PARALLELS = 10,
   parameter int MERIDIANS = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // meridian_number[5:0], parallel_number[11:6]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // pos_x, pos_y, pos_z, red, green, blue, vertex_number,
                                     // ring_order_slot, face_present, corner_right,
                                     // corner_upper_right, corner_above
   input  logic         csr_we,
   input  logic [9:0]   csr_wdata    // sphere_radius
);
   import svg_pkg::*;
   `include "sphere_vertex_generator_macros.svh"

   localparam int Depth = 10;            // valid stages
   localparam int Ring  = PARALLELS + 1;

   logic [9:0]      radius_ff;
   logic [Depth-1:0] vld_ff;
   logic             adv;
   side_type         side_ff [Depth];
   side_type         side_in;

   // pipe moves when the last stage is empty or being drained
   assign adv        = !vld_ff[Depth-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) radius_ff <= 10'd50;
      else if (csr_we) radius_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
   end

   // angle phases, constant division on narrow input via elaboration table
   logic [5:0]  m, p;
   logic [23:0] lat, lon, lat_c, lon_c;
   assign m = req_tdata[5:0];
   assign p = req_tdata[11:6];

   function automatic logic [23:0] lat_of(input logic [5:0] pp);
      logic [31:0] q;
      begin
         q = ((32'(pp) << 24) + 32'(PARALLELS)) / 32'(2 * PARALLELS);
         lat_of = 24'(32'h00C00000 + q);
      end
   endfunction

   function automatic logic [23:0] lon_of(input logic [5:0] mm);
      logic [31:0] q;
      begin
         q = ((32'(mm) << 25) + 32'(MERIDIANS)) / 32'(2 * MERIDIANS);
         lon_of = 24'(q);
      end
   endfunction

   typedef logic [23:0] ptab_type [64];
   function automatic ptab_type mk_lat();
      ptab_type t;
      begin
         for (int i = 0; i < 64; i++) t[i] = lat_of(6'(i));
         mk_lat = t;
      end
   endfunction
   function automatic ptab_type mk_lon();
      ptab_type t;
      begin
         for (int i = 0; i < 64; i++) t[i] = lon_of(6'(i));
         mk_lon = t;
      end
   endfunction
   localparam ptab_type LatTab = mk_lat();
   localparam ptab_type LonTab = mk_lon();

   assign lat   = LatTab[p];
   assign lon   = LonTab[m];
   assign lat_c = lat + 24'h400000;
   assign lon_c = lon + 24'h400000;

   // index arithmetic, small constant multiplies
   logic [13:0] vtx, slot, cr;
   logic [6:0]  nxt;
   logic        face;
   always_comb begin
      vtx  = 14'(m) * 14'(Ring) + 14'(p);
      slot = 14'(Ring * MERIDIANS) + 14'(p) * 14'(MERIDIANS) + 14'(m);
      nxt  = (7'(m) + 7'd1 >= 7'(MERIDIANS)) ? 7'd0 : 7'(m) + 7'd1;
      cr   = 14'(nxt) * 14'(Ring) + 14'(p);
      face = 7'(p) < 7'(PARALLELS);
      side_in.radius             = radius_ff;
      side_in.vertex_number      = (vtx > 14'd4095) ? 12'd4095 : vtx[11:0];
      side_in.ring_order_slot    = (slot > 14'd8191) ? 13'd8191 : slot[12:0];
      side_in.face_present       = face;
      side_in.corner_right       = !face ? 12'd0 : ((cr > 14'd4095) ? 12'd4095 : cr[11:0]);
      side_in.corner_upper_right = !face ? 12'd0 :
                                   ((cr + 14'd1 > 14'd4095) ? 12'd4095 : 12'(cr + 14'd1));
      side_in.corner_above       = !face ? 12'd0 :
                                   ((vtx + 14'd1 > 14'd4095) ? 12'd4095 : 12'(vtx + 14'd1));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < Depth; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // four sine chains, six stages each (stages 0..5)
   logic signed [31:0] su, cu, sv, cv;
   svg_sin_chain u_su (.clock(clock), .en(adv), .phase(lat),   .sin_q30(su));
   svg_sin_chain u_cu (.clock(clock), .en(adv), .phase(lat_c), .sin_q30(cu));
   svg_sin_chain u_sv (.clock(clock), .en(adv), .phase(lon),   .sin_q30(sv));
   svg_sin_chain u_cv (.clock(clock), .en(adv), .phase(lon_c), .sin_q30(cv));

   // stage 6: cos*cos, cos*sin products; stage 7: round; stage 8: radius scale
   logic signed [63:0] pxy_x_ff, pxy_y_ff;
   logic signed [31:0] su6_ff, cv6_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         pxy_x_ff <= 64'(cu) * 64'(cv);
         pxy_y_ff <= 64'(cu) * 64'(sv);
         su6_ff   <= su;
         cv6_ff   <= cv;
      end
   end

   logic signed [31:0] tx_ff, ty_ff, su7_ff, cv7_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         tx_ff  <= 32'(rnd_shift(pxy_x_ff, 30));
         ty_ff  <= 32'(rnd_shift(pxy_y_ff, 30));
         su7_ff <= su6_ff;
         cv7_ff <= cv6_ff;
      end
   end

   logic signed [63:0] rx_ff, ry_ff, rz_ff;
   logic signed [31:0] su8_ff, cv8_ff;
   logic signed [63:0] rad;
   assign rad = 64'(side_ff[7].radius);
   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff  <= rad * 64'(tx_ff);
         ry_ff  <= rad * 64'(ty_ff);
         rz_ff  <= rad * 64'(su7_ff);
         su8_ff <= su7_ff;
         cv8_ff <= cv7_ff;
      end
   end

   // stage 9: rounding, saturation, output register
   logic [14:0] px_ff, py_ff, pz_ff;
   logic [15:0] cr_ff, cg_ff, cb_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= 15'(sat64(rnd_shift(rx_ff, 26), -64'sd16384, 64'sd16383));
         py_ff <= 15'(sat64(rnd_shift(ry_ff, 26), -64'sd16384, 64'sd16383));
         pz_ff <= 15'(sat64(rnd_shift(rz_ff, 26), -64'sd16384, 64'sd16383));
         cr_ff <= 16'(sat64(rnd_shift(64'(TenthQ30) + 64'(su8_ff), 18),
                            -64'sd32768, 64'sd32767));
         cg_ff <= 16'(sat64(rnd_shift(64'(TenthQ30) + 64'(cv8_ff), 18),
                            -64'sd32768, 64'sd32767));
         cb_ff <= 16'(sat64(rnd_shift(64'(TenthQ31) - 64'sd3 * 64'(su8_ff), 19),
                            -64'sd32768, 64'sd32767));
      end
   end

   assign rsp_tdata = {5'd0,
                       side_ff[9].corner_above, side_ff[9].corner_upper_right,
                       side_ff[9].corner_right, side_ff[9].face_present,
                       side_ff[9].ring_order_slot, side_ff[9].vertex_number,
                       cb_ff, cg_ff, cr_ff, pz_ff, py_ff, px_ff};

   // a stalled word must not be overwritten by the pipe
   `SVG_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled word changed")
   // no face means zero corners
   `SVG_ASSERT_IMP(a_noface, clock, reset, rsp_tvalid && !rsp_tdata[118], rsp_tdata[154:119] == 36'd0, "corners set without face")
   // input is always ready when the output stage is empty
   `SVG_ASSERT_IMP(a_ready, clock, reset, !rsp_tvalid, req_tready, "pipe stalled while empty at output")
endmodule

@@ hw/rtl/svg_sin_cell.sv @@
// one horner step: acc <= coef - (acc*x2 >> 30), one product per cycle while en is high
module svg_sin_cell #(
   parameter int Coef = 0
) (
   input  logic                clock,
   input  logic                en,
   input  svg_pkg::sin_type    d_in,
   output svg_pkg::sin_type    d_out
);
   import svg_pkg::*;

   sin_type     step_ff;
   logic [62:0] prod;

   assign prod = 63'(d_in.acc) * 63'(d_in.x2);

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff.quad <= d_in.quad;
         step_ff.x    <= d_in.x;
         step_ff.x2   <= d_in.x2;
         step_ff.acc  <= 32'(PolyQ30[Coef] - 32'(prod >> 30));
      end
   end

   assign d_out = step_ff;
endmodule

@@ hw/rtl/svg_sin_chain.sv @@
// phase -> signed Q30 sine; fold, square, four horner cells, final multiply
module svg_sin_chain (
   input  logic                     clock,
   input  logic                     en,
   input  logic [svg_pkg::PhaseW-1:0] phase,
   output logic signed [31:0]       sin_q30
);
   import svg_pkg::*;

   sin_type     head_ff;
   sin_type     link [5];
   logic [30:0] x_in;
   logic [61:0] sq;
   logic [62:0] last_prod;
   logic [31:0] mag;
   logic signed [31:0] out_ff;

   always_comb begin
      x_in = 31'({phase[21:0], 8'd0});
      if (phase[22]) x_in = 31'(OneQ30 - 32'(x_in));
      sq = x_in * x_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         head_ff.quad <= phase[23:22];
         head_ff.x    <= x_in;
         head_ff.x2   <= 31'(sq >> 30);
         head_ff.acc  <= PolyQ30[4];
      end
   end

   assign link[0] = head_ff;

   for (genvar k = 0; k < 4; k++) begin : g_cell
      svg_sin_cell #(.Coef(3 - k)) u_cell (
         .clock (clock),
         .en    (en),
         .d_in  (link[k]),
         .d_out (link[k+1])
      );
   end

   always_comb begin
      last_prod = 63'(link[4].acc) * 63'(link[4].x);
      mag = 32'(last_prod >> 30);
      if (mag > OneQ30) mag = OneQ30;
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= link[4].quad[1] ? -$signed(mag) : $signed(mag);
   end

   assign sin_q30 = out_ff;
endmodule

@@ test/tb.sv @@
module tb;
   import svg_pkg::*;

   localparam int PARALLELS = 10;
   localparam int MERIDIANS = 20;
   localparam int PIPE_LAT  = 10;

   // one result word, last field in the lowest bits
   typedef struct packed {
      logic [11:0]        corner_above;
      logic [11:0]        corner_upper_right;
      logic [11:0]        corner_right;
      logic               face_present;
      logic [12:0]        ring_order_slot;
      logic [11:0]        vertex_number;
      logic signed [15:0] color_blue;
      logic signed [15:0] color_green;
      logic signed [15:0] color_red;
      logic signed [14:0] pos_z;
      logic signed [14:0] pos_y;
      logic signed [14:0] pos_x;
   } vertex_type;

   // directed rows: grid point plus a typed vertex index where it is obvious
   typedef struct {
      logic [5:0]  meridian;
      logic [5:0]  parallel;
      bit          typed;
      logic [11:0] vertex_number;
   } grid_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;   // meridian_number[5:0], parallel_number[11:6]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [159:0] rsp_tdata;   // pos_x .. corner_above, see vertex_type
   logic         csr_we;
   logic [9:0]   csr_wdata;   // sphere_radius

   vertex_type   vertex_queue[$];
   logic [9:0]   radius_copy;
   int           errors;
   bit           no_idle;

   sphere_vertex_generator #(.PARALLELS(PARALLELS), .MERIDIANS(MERIDIANS)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // round to nearest, halves away from zero
   function automatic longint round_off(input longint v, input int s);
      longint unsigned half;
      half = 64'd1 << (s - 1);
      if (v < 0) return -longint'((longint'(-v) + half) >> s);
      return longint'((longint'(v) + half) >> s);
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // folded quarter wave, odd polynomial in x, Q30 out
   function automatic longint sine_q30(input logic [31:0] phase);
      logic [23:0]     a;
      longint unsigned x, x2, acc;
      a   = phase[23:0];
      x   = longint'({a[21:0], 8'b0});
      if (a[22]) x = 64'd1073741824 - x;
      x2  = (x * x) >> 30;
      acc = longint'(PolyQ30[4]);
      for (int k = 3; k >= 0; k--) acc = longint'(PolyQ30[k]) - ((acc * x2) >> 30);
      acc = (acc * x) >> 30;
      if (acc > 64'd1073741824) acc = 64'd1073741824;
      return a[23] ? -longint'(acc) : longint'(acc);
   endfunction

   function automatic vertex_type grid_vertex(input logic [5:0] m, input logic [5:0] p,
                                              input logic [9:0] radius);
      vertex_type      v;
      longint unsigned lat, lon, vtx, slot, nxt, right;
      longint          su, cu, sv, cv, r, t;
      lat = (64'h0C00000 + ((longint'(p) << 24) + PARALLELS) / (2 * PARALLELS)) & 64'hFFFFFF;
      lon = (((longint'(m) << 25) + MERIDIANS) / (2 * MERIDIANS)) & 64'hFFFFFF;
      su = sine_q30(32'(lat));
      cu = sine_q30(32'(lat + 64'h400000));
      sv = sine_q30(32'(lon));
      cv = sine_q30(32'(lon + 64'h400000));
      r  = longint'(radius);
      t  = round_off(cu * cv, 30);
      v.pos_x = 15'(clamp(round_off(r * t, 26), -16384, 16383));
      t  = round_off(cu * sv, 30);
      v.pos_y = 15'(clamp(round_off(r * t, 26), -16384, 16383));
      v.pos_z = 15'(clamp(round_off(r * su, 26), -16384, 16383));
      v.color_red   = 16'(clamp(round_off(longint'(TenthQ30) + su, 18), -32768, 32767));
      v.color_green = 16'(clamp(round_off(longint'(TenthQ30) + cv, 18), -32768, 32767));
      v.color_blue  = 16'(clamp(round_off(longint'(TenthQ31) - 3 * su, 19), -32768, 32767));
      vtx  = 64'(m * (PARALLELS + 1) + p);
      slot = 64'((PARALLELS + 1) * MERIDIANS + p * MERIDIANS + m);
      v.vertex_number   = (vtx > 4095) ? 12'd4095 : vtx[11:0];
      v.ring_order_slot = (slot > 8191) ? 13'd8191 : slot[12:0];
      v.face_present    = (p < PARALLELS);
      v.corner_right = '0;
      v.corner_upper_right = '0;
      v.corner_above = '0;
      if (v.face_present) begin
         // last meridian and anything past it wrap to meridian 0
         nxt   = (m + 1 >= MERIDIANS) ? 64'd0 : 64'(m + 1);
         right = nxt * (PARALLELS + 1) + p;
         v.corner_right       = (right > 4095) ? 12'd4095 : right[11:0];
         v.corner_upper_right = (right + 1 > 4095) ? 12'd4095 : 12'(right + 1);
         v.corner_above       = (vtx + 1 > 4095) ? 12'd4095 : 12'(vtx + 1);
      end
      return v;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= (idle_gap() == 0);
      end
   end

   // result checker: compare against the oldest expected vertex
   always @(posedge clock) begin
      vertex_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = vertex_type'(rsp_tdata[$bits(vertex_type)-1:0]);
         if (vertex_queue.size() == 0) begin
            $display("%0t: unexpected rsp word %h", $time, got);
            errors++;
         end else begin
            want = vertex_queue.pop_front();
            if (got.pos_x !== want.pos_x)
               $display("%0t: pos_x exp %0d got %0d", $time, want.pos_x, got.pos_x);
            if (got.pos_y !== want.pos_y)
               $display("%0t: pos_y exp %0d got %0d", $time, want.pos_y, got.pos_y);
            if (got.pos_z !== want.pos_z)
               $display("%0t: pos_z exp %0d got %0d", $time, want.pos_z, got.pos_z);
            if (got.color_red !== want.color_red)
               $display("%0t: red exp %0d got %0d", $time, want.color_red, got.color_red);
            if (got.color_green !== want.color_green)
               $display("%0t: green exp %0d got %0d", $time, want.color_green,
                        got.color_green);
            if (got.color_blue !== want.color_blue)
               $display("%0t: blue exp %0d got %0d", $time, want.color_blue, got.color_blue);
            if (got.vertex_number !== want.vertex_number)
               $display("%0t: vertex exp %0d got %0d", $time, want.vertex_number,
                        got.vertex_number);
            if (got.ring_order_slot !== want.ring_order_slot)
               $display("%0t: slot exp %0d got %0d", $time, want.ring_order_slot,
                        got.ring_order_slot);
            if (got.face_present !== want.face_present)
               $display("%0t: face exp %0d got %0d", $time, want.face_present,
                        got.face_present);
            if (got.corner_right !== want.corner_right)
               $display("%0t: right exp %0d got %0d", $time, want.corner_right,
                        got.corner_right);
            if (got.corner_upper_right !== want.corner_upper_right)
               $display("%0t: upper right exp %0d got %0d", $time, want.corner_upper_right,
                        got.corner_upper_right);
            if (got.corner_above !== want.corner_above)
               $display("%0t: above exp %0d got %0d", $time, want.corner_above,
                        got.corner_above);
            if (got !== want) errors++;
         end
      end
   end

   // push one grid point, leaving tvalid high after the handshake
   task automatic send_point(input logic [5:0] m, input logic [5:0] p, input bit typed,
                             input logic [11:0] typed_vertex);
      int         gap;
      vertex_type want;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, p, m};
      do @(posedge clock); while (!req_tready);
      want = grid_vertex(m, p, radius_copy);
      if (typed) want.vertex_number = typed_vertex;
      vertex_queue.push_back(want);
   endtask

   // drain the pipe fully before touching the radius
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 2) @(posedge clock);
   endtask

   task automatic write_radius(input logic [9:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      radius_copy = value;
   endtask

   grid_row_type grid_rows[] = '{
      '{6'd0,  6'd0,  1, 12'd0},     // south pole, first meridian
      '{6'd0,  6'd10, 1, 12'd10},    // north pole, no face
      '{6'd0,  6'd5,  1, 12'd5},     // equator
      '{6'd19, 6'd0,  1, 12'd209},   // last meridian wraps to 0
      '{6'd19, 6'd9,  1, 12'd218},
      '{6'd19, 6'd10, 1, 12'd219},
      '{6'd5,  6'd5,  0, 12'd0},     // quarter turn of longitude
      '{6'd10, 6'd5,  0, 12'd0},
      '{6'd15, 6'd5,  0, 12'd0},
      '{6'd7,  6'd3,  0, 12'd0},
      '{6'd20, 6'd4,  1, 12'd224},   // meridian out of range wraps
      '{6'd63, 6'd0,  1, 12'd693},
      '{6'd0,  6'd11, 1, 12'd11},    // past the pole
      '{6'd3,  6'd20, 0, 12'd0},     // a full turn of latitude
      '{6'd0,  6'd63, 1, 12'd63},
      '{6'd63, 6'd63, 1, 12'd756},
      '{6'd42, 6'd21, 0, 12'd0},
      '{6'd21, 6'd42, 0, 12'd0},
      '{6'd1,  6'd1,  0, 12'd0},
      '{6'd12, 6'd7,  0, 12'd0}
   };

   logic [9:0] radius_plan[5];

   initial begin
      errors      = 0;
      no_idle     = 0;
      radius_copy = 10'd50;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset radius
      foreach (grid_rows[i])
         send_point(grid_rows[i].meridian, grid_rows[i].parallel, grid_rows[i].typed,
                    grid_rows[i].vertex_number);
      drain_pipe();

      radius_plan = '{10'd0, 10'd1023, 10'd1, 10'($urandom_range(2, 1022)), 10'd50};
      for (int ph = 0; ph < 5; ph++) begin
         write_radius(radius_plan[ph]);
         no_idle = (ph == 2);
         for (int n = 0; n < 340; n++) begin
            if ($urandom_range(0, 99) < 85)
               send_point(6'($urandom_range(0, MERIDIANS - 1)),
                          6'($urandom_range(0, PARALLELS)), 0, '0);
            else
               send_point(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 0, '0);
         end
         no_idle = 0;
         drain_pipe();
      end

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/svg_pkg.sv
hw/rtl/svg_sin_cell.sv
hw/rtl/svg_sin_chain.sv
hw/rtl/sphere_vertex_generator.sv
test/tb.sv
